// File: sv/sbda_pkg.sv
// shared constants and types for the signed binary to decimal ascii converter
// no dependencies; imported by the front, back and top modules of the block
package sbda_pkg;

    // fixed field widths of the stream ports
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    // binary bits folded into the bcd register per conversion cycle
    localparam int DD_BITS = 4;

    // entries in the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_TRIM,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

endpackage

// File: sv/sbda_fifo.sv
// small flop-based queue between the front and back parts
// depends on nothing; DEPTH must be a power of two, at least 2
module sbda_fifo #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/sbda_front.sv
// front part: takes input beats, splits off sign and magnitude, queues them
// depends on sbda_pkg and sbda_fifo
module sbda_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbda_pkg::VALUE_W-1:0] s_tdata,
    output logic                         q_valid,
    output logic [VALUE_BITS:0]          q_data,
    input  logic                         q_pop
);

    import sbda_pkg::*;

    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  full;

    // bits from VALUE_BITS up are ignored; magnitude as unsigned covers the most negative value
    assign value    = s_tdata[VALUE_BITS-1:0];
    assign neg      = value[VALUE_BITS-1];
    assign mag      = neg ? (~value + VALUE_BITS'(1)) : value;
    assign s_tready = !full;

    sbda_fifo #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data ({neg, mag}),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

endmodule

// File: sv/sbda_back.sv
// back part: shift-add-3 bcd conversion, leading zero trim, character output stage
// depends on sbda_pkg
module sbda_back #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  logic [VALUE_BITS:0]         q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sbda_pkg::CHAR_W-1:0] m_tdata,
    output logic                        m_tlast
);

    import sbda_pkg::*;

    localparam int SH_BITS    = ((VALUE_BITS + DD_BITS - 1) / DD_BITS) * DD_BITS;
    localparam int STEPS      = SH_BITS / DD_BITS;
    localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int KEEP       = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int KEEP_W     = KEEP * 4;
    localparam int STEP_CW    = $clog2(STEPS + 1);
    localparam int CNT_W      = $clog2(KEEP + 1);

    back_state_t          state_reg, state_next;
    logic [SH_BITS-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic                 neg_reg, neg_next;
    logic [STEP_CW-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    logic [BCD_W-1:0]     dd_bcd;
    logic [SH_BITS-1:0]   dd_bin;
    logic                 upper_nz;
    logic [3:0]           top_digit;
    logic                 can_load;

    // DD_BITS shift-add-3 steps per cycle
    always_comb begin
        dd_bcd = bcd_reg;
        dd_bin = bin_reg;
        for (int s = 0; s < DD_BITS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (dd_bcd[d*4 +: 4] >= 4'd5) begin
                    dd_bcd[d*4 +: 4] = dd_bcd[d*4 +: 4] + 4'd3;
                end
            end
            dd_bcd = {dd_bcd[BCD_W-2:0], dd_bin[SH_BITS-1]};
            dd_bin = {dd_bin[SH_BITS-2:0], 1'b0};
        end
    end

    // digits beyond the kept window force the full window out
    generate
        if (BCD_DIGITS > KEEP) begin : g_upper
            assign upper_nz = |bcd_reg[BCD_W-1:KEEP_W];
        end else begin : g_no_upper
            assign upper_nz = 1'b0;
        end
    endgenerate

    assign top_digit = bcd_reg[KEEP_W-1 -: 4];
    assign can_load  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    neg_next   = q_data[VALUE_BITS];
                    bin_next   = SH_BITS'(q_data[VALUE_BITS-1:0]);
                    bcd_next   = '0;
                    step_next  = STEP_CW'(STEPS);
                    state_next = BK_CONV;
                end
            end
            BK_CONV: begin
                bcd_next  = dd_bcd;
                bin_next  = dd_bin;
                step_next = step_reg - STEP_CW'(1);
                if (step_reg == STEP_CW'(1)) begin
                    cnt_next   = CNT_W'(KEEP);
                    state_next = BK_TRIM;
                end
            end
            BK_TRIM: begin
                if (!upper_nz && cnt_reg > CNT_W'(1) && top_digit == 4'd0) begin
                    bcd_next[KEEP_W-1:0] = {bcd_reg[KEEP_W-5:0], 4'd0};
                    cnt_next             = cnt_reg - CNT_W'(1);
                end else begin
                    state_next = neg_reg ? BK_SIGN : BK_DIGIT;
                end
            end
            BK_SIGN: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = BK_DIGIT;
                end
            end
            BK_DIGIT: begin
                if (can_load) begin
                    out_valid_next       = 1'b1;
                    out_char_next        = CH_ZERO + CHAR_W'(top_digit);
                    out_last_next        = (cnt_reg == CNT_W'(1));
                    bcd_next[KEEP_W-1:0] = {bcd_reg[KEEP_W-5:0], 4'd0};
                    cnt_next             = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: sv/signed_binary_to_decimal_ascii.sv
// top level of the signed binary to decimal ascii converter
// depends on sbda_pkg, sbda_front (with sbda_fifo) and sbda_back
//
// Each input beat carries one two's complement integer; only its low VALUE_BITS
// bits count, sign-extended from bit VALUE_BITS-1. The block answers with the
// decimal text of that integer, one ascii character per output beat, most
// significant first: a leading '-' for negative values, no leading zeros, and
// a single '0' for zero. The most negative value is printed in full. If the
// magnitude has more than MAX_DIGITS digits, only the MAX_DIGITS low digits go
// out (leading zeros among them included). m_tlast marks the last character of
// each number. Per number the back takes it from the input queue, runs the
// shift-add-3 conversion (four binary bits per cycle), then walks the kept
// digit positions, first dropping leading zeros in the zero trim, then sending
// the '-' for a negative value and one character per digit as the output side
// accepts them. A two-entry queue lets the input side keep accepting, until it
// is full, while a number is being converted and sent.
module signed_binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 20,   // 3 .. 20
    parameter int VALUE_BITS = 64    // 8 .. 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbda_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sbda_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] char_code
    output logic                         m_tlast    // last_char
);

    import sbda_pkg::*;

    // queue between front and back: sign in the top bit, magnitude below
    logic                  q_valid;
    logic [VALUE_BITS:0]   q_data;
    logic                  q_pop;

    // front: sign split and magnitude, queued
    sbda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // back: bcd conversion, zero trim and character beats
    sbda_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // every character beat is a digit, or a minus that never ends the text
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata == CH_MINUS && !m_tlast) ||
                      (m_tdata >= CH_ZERO && m_tdata <= CH_NINE)))
        else $error("illegal character beat");

    // the back only takes a number when the queue holds one
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

endmodule
